// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hfa_pkg.sv =====
// types and constants of the hole fit allocator
`default_nettype none

package hfa_pkg;

   localparam int HOLE_IDX_BITS   = 6;
   localparam int FIELD_SIZE_BITS = 32;
   localparam int POLICY_BITS     = 2;
   localparam int COUNT_BITS      = 7;
   localparam int CSR_DATA_BITS   = 7;
   localparam int CSR_INDEX_BITS  = 1;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_ALLOC = 1'b1
   } hfa_op_type;

   localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_POLICY = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLE_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_LAST,
      ST_COMMIT,
      ST_DONE
   } hfa_state_type;

   typedef struct packed {
      logic                       operation;
      logic [HOLE_IDX_BITS-1:0]   hole_index;
      logic [FIELD_SIZE_BITS-1:0] hole_size;
      logic [FIELD_SIZE_BITS-1:0] request_size;
   } hfa_req_type;

   typedef struct packed {
      logic                       granted;
      logic [HOLE_IDX_BITS-1:0]   chosen_hole;
      logic [FIELD_SIZE_BITS-1:0] left_in_hole;
   } hfa_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hfa_req_if.sv =====
// request channel interface of the hole fit allocator
`default_nettype none

interface hfa_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [5:0]  hole_index;
   logic [31:0] hole_size;
   logic [31:0] request_size;

   modport source (output valid, output operation, output hole_index,
                   output hole_size, output request_size, input ready);
   modport sink   (input valid, input operation, input hole_index,
                   input hole_size, input request_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hfa_rsp_if.sv =====
// response channel interface of the hole fit allocator
`default_nettype none

interface hfa_rsp_if;
   logic        valid;
   logic        ready;
   logic        granted;
   logic [5:0]  chosen_hole;
   logic [31:0] left_in_hole;

   modport source (output valid, output granted, output chosen_hole,
                   output left_in_hole, input ready);
   modport sink   (input valid, input granted, input chosen_hole,
                   input left_in_hole, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hfa_mem.sv =====
// hole size memory, one write and one registered read port
`default_nettype none

module hfa_mem #(
   parameter int DEPTH     = 64,
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hfa_core.sv =====
// sequencer and scan datapath of the hole fit allocator
`default_nettype none

module hfa_core
   import hfa_pkg::*;
#(
   parameter int HOLES     = 64,
   parameter int SIZE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hfa_req_type            req_item,
   input  logic [POLICY_BITS-1:0] fit_policy,
   input  logic [(($clog2(HOLES+1) > COUNT_BITS) ? $clog2(HOLES+1) : COUNT_BITS)-1:0]
                                  used_count,
   output logic                   res_valid,
   input  logic                   res_take,
   output hfa_result_type         res
);

   localparam int AW = (HOLES > 1) ? $clog2(HOLES) : 1;
   localparam int CW = ($clog2(HOLES+1) > COUNT_BITS) ? $clog2(HOLES+1) : COUNT_BITS;

   hfa_state_type state_ff, state_in;

   logic [HOLE_IDX_BITS-1:0]     idx_ff, idx_in;
   logic [SIZE_BITS-1:0]         hsz_ff, hsz_in;
   logic [SIZE_BITS-1:0]         rsz_ff, rsz_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [AW-1:0]                rd_idx_ff, rd_idx_in;
   logic                         found_ff, found_in;
   logic [AW-1:0]                pick_ff, pick_in;
   logic [SIZE_BITS-1:0]         best_ff, best_in;
   hfa_result_type               res_ff, res_in;

   logic                         mem_we, mem_re;
   logic [AW-1:0]                mem_waddr;
   logic [SIZE_BITS-1:0]         mem_wdata, mem_rdata;

   logic                         accept;
   logic                         in_range;
   logic                         fits, take;
   logic [SIZE_BITS-1:0]         remain;
   logic [AW+HOLE_IDX_BITS-1:0]  idx_wide, pick_wide;
   logic [SIZE_BITS+FIELD_SIZE_BITS-1:0] hsz_wide, rsz_wide, hsz_out_wide, remain_wide;

   assign accept   = req_valid && req_ready;
   assign in_range = CW'(idx_ff) < CW'(HOLES);
   assign remain   = best_ff - rsz_ff;

   // size and index conversions between field and storage widths
   assign hsz_wide     = {{SIZE_BITS{1'b0}}, req_item.hole_size};
   assign rsz_wide     = {{SIZE_BITS{1'b0}}, req_item.request_size};
   assign hsz_out_wide = {{FIELD_SIZE_BITS{1'b0}}, hsz_ff};
   assign remain_wide  = {{FIELD_SIZE_BITS{1'b0}}, remain};
   assign idx_wide     = {{AW{1'b0}}, idx_ff};
   assign pick_wide    = {{HOLE_IDX_BITS{1'b0}}, pick_ff};

   // candidate test on the entry read last cycle
   always_comb begin
      fits = rd_valid_ff && (rsz_ff <= mem_rdata);
      case (fit_policy)
         POLICY_BEST:  take = fits && (!found_ff || mem_rdata <= best_ff);
         POLICY_WORST: take = fits && (!found_ff || mem_rdata >= best_ff);
         default:      take = fits && !found_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.operation == OP_LOAD) begin
                  state_in = ST_LOAD;
               end else if (used_count == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOAD:   state_in = ST_DONE;
         ST_SCAN: begin
            if (CW'(addr_ff) + CW'(1) == used_count) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = pick_ff;
      mem_wdata = remain;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LOAD: begin
            mem_we    = in_range;
            mem_waddr = idx_wide[AW-1:0];
            mem_wdata = hsz_ff;
         end
         ST_SCAN:   mem_re = 1'b1;
         ST_COMMIT: mem_we = found_ff;
         ST_DONE:   res_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      idx_in      = idx_ff;
      hsz_in      = hsz_ff;
      rsz_in      = rsz_ff;
      addr_in     = addr_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      best_in     = best_ff;
      res_in      = res_ff;
      rd_valid_in = mem_re;
      rd_idx_in   = addr_ff;
      if (accept) begin
         idx_in   = req_item.hole_index;
         hsz_in   = hsz_wide[SIZE_BITS-1:0];
         rsz_in   = rsz_wide[SIZE_BITS-1:0];
         addr_in  = '0;
         found_in = 1'b0;
         res_in   = '0;
      end
      if (state_ff == ST_SCAN) begin
         addr_in = addr_ff + AW'(1);
      end
      if (take) begin
         found_in = 1'b1;
         pick_in  = rd_idx_ff;
         best_in  = mem_rdata;
      end
      if (state_ff == ST_LOAD) begin
         if (in_range) begin
            res_in.granted      = 1'b1;
            res_in.chosen_hole  = idx_ff;
            res_in.left_in_hole = hsz_out_wide[FIELD_SIZE_BITS-1:0];
         end else begin
            res_in = '0;
         end
      end
      if (state_ff == ST_COMMIT) begin
         if (found_ff) begin
            res_in.granted      = 1'b1;
            res_in.chosen_hole  = pick_wide[HOLE_IDX_BITS-1:0];
            res_in.left_in_hole = remain_wide[FIELD_SIZE_BITS-1:0];
         end else begin
            res_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      hsz_ff    <= hsz_in;
      rsz_ff    <= rsz_in;
      addr_ff   <= addr_in;
      rd_idx_ff <= rd_idx_in;
      pick_ff   <= pick_in;
      best_ff   <= best_in;
      res_ff    <= res_in;
   end

   assign res = res_ff;

   hfa_mem #(
      .DEPTH     (HOLES),
      .WIDTH     (SIZE_BITS),
      .ADDR_BITS (AW)
   ) u_hfa_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (addr_ff),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/hole_fit_allocator.sv =====
// hole fit allocator: first, best or worst fit over a table of free hole sizes
// a load passes through the load and done states; an allocate scans the holes in use,
//   then the last, commit and done states (straight to done when no hole is in use)
// one transaction at a time: a request is taken only in the idle state, and the scan
//   reads the holes in use over the single read port of the hole memory
// reset: synchronous, clears control and csr registers; the hole memory is not cleared
`default_nettype none

module hole_fit_allocator
   import hfa_pkg::*;
#(
   parameter int HOLES     = 64,
   parameter int SIZE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   hfa_req_if.sink                   req_ch,
   hfa_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW = ($clog2(HOLES+1) > COUNT_BITS) ? $clog2(HOLES+1) : COUNT_BITS;

   // csr registers
   logic [POLICY_BITS-1:0] fit_policy_ff, fit_policy_in;
   logic [COUNT_BITS-1:0]  hole_count_ff, hole_count_in;

   // holes in use, clamped to the table depth
   logic [CW-1:0]          used_count;

   // core handshake and response holding register
   hfa_req_type            req_item;
   logic                   core_ready;
   logic                   res_valid;
   logic                   res_take;
   hfa_result_type         res;
   logic                   rsp_valid_ff, rsp_valid_in;
   hfa_result_type         rsp_data_ff, rsp_data_in;

   always_comb begin
      fit_policy_in = fit_policy_ff;
      hole_count_in = hole_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIT_POLICY: fit_policy_in = csr_wdata[POLICY_BITS-1:0];
            CSR_HOLE_COUNT: hole_count_in = csr_wdata[COUNT_BITS-1:0];
            default: begin
               fit_policy_in = fit_policy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff <= POLICY_FIRST;
         hole_count_ff <= '0;
      end else begin
         fit_policy_ff <= fit_policy_in;
         hole_count_ff <= hole_count_in;
      end
   end

   assign used_count = (CW'(hole_count_ff) > CW'(HOLES)) ? CW'(HOLES) : CW'(hole_count_ff);

   assign req_item.operation    = req_ch.operation;
   assign req_item.hole_index   = req_ch.hole_index;
   assign req_item.hole_size    = req_ch.hole_size;
   assign req_item.request_size = req_ch.request_size;
   assign req_ch.ready          = core_ready;

   hfa_core #(
      .HOLES     (HOLES),
      .SIZE_BITS (SIZE_BITS)
   ) u_hfa_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (core_ready),
      .req_item   (req_item),
      .fit_policy (fit_policy_ff),
      .used_count (used_count),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res)
   );

   // response register: the core moves on as soon as the slot is free
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.granted      = rsp_data_ff.granted;
   assign rsp_ch.chosen_hole  = rsp_data_ff.chosen_hole;
   assign rsp_ch.left_in_hole = rsp_data_ff.left_in_hole;

endmodule

`default_nettype wire

// ===== hw/rtl/hfa_checker.sv =====
// port-level assertions of the hole fit allocator and their bind
`default_nettype none
`include "assert_macros.svh"

module hfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_granted,
   input logic [5:0]  rsp_chosen_hole,
   input logic [31:0] rsp_left_in_hole
);

   // one transaction in flight: no back-to-back acceptance
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // a refused request carries zero payload
   `ASSERT_IMPLIES(a_refused_zero, clock, reset, rsp_valid && !rsp_granted, rsp_chosen_hole == 6'd0 && rsp_left_in_hole == 32'd0, "refused response with nonzero payload")

   // a stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted) && $stable(rsp_chosen_hole) && $stable(rsp_left_in_hole), "stalled response changed")

   // no response right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid, "response valid after reset")

endmodule

bind hole_fit_allocator hfa_checker u_hfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_granted      (rsp_ch.granted),
   .rsp_chosen_hole  (rsp_ch.chosen_hole),
   .rsp_left_in_hole (rsp_ch.left_in_hole)
);

`default_nettype wire

// ===== bench/hole_fit_allocator_tb.sv =====
// self-checking testbench of the hole fit allocator: fit policies, hole loads and allocations
module hole_fit_allocator_tb;
   import hfa_pkg::*;

   localparam int HOLE_TOTAL   = 64;
   localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either channel
   localparam int DRAIN_CYCLES = 80;    // wait before the final check for responses never seen
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 26;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   hfa_req_if req_if ();
   hfa_rsp_if rsp_if ();

   hole_fit_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // settings walked by the random phases, extremes of hole_count among them
   logic [POLICY_BITS-1:0] policy_plan [PHASES] = '{
      POLICY_FIRST, POLICY_BEST, POLICY_WORST, 2'd3, POLICY_BEST, POLICY_WORST,
      POLICY_FIRST, POLICY_WORST, POLICY_BEST, POLICY_FIRST, POLICY_WORST, POLICY_BEST
   };
   logic [COUNT_BITS-1:0] count_plan [PHASES] = '{
      7'd1, 7'd64, 7'd8, 7'd127, 7'd0, 7'd3, 7'd64, 7'd16, 7'd2, 7'd40, 7'd5, 7'd64
   };

   // shadow of the allocator: hole table and csr copies
   logic [FIELD_SIZE_BITS-1:0] hole_free_model [HOLE_TOTAL];
   logic [POLICY_BITS-1:0]     fit_sel;
   logic [COUNT_BITS-1:0]      holes_in_use;

   hfa_req_type    txn_q [$];    // transactions waiting for the driver
   hfa_result_type grant_q [$];  // predicted responses, oldest first

   int  outstanding;     // transactions queued but not yet answered
   int  error_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  quiet_cycles;
   int  load_count;
   int  alloc_count;
   int  grant_count;
   int  csr_writes;
   logic req_taken;      // request accepted at the last rising edge

   // clock: period 8
   always #4 clock = ~clock;

   // one line per mismatch, counted
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // works out the response of one transaction and updates the hole table
   function automatic hfa_result_type predict_grant(input hfa_req_type it);
      hfa_result_type             r;
      int                         used;
      int                         pick;
      bit                         found;
      bit                         stop;
      logic [FIELD_SIZE_BITS-1:0] f;
      r     = '0;
      pick  = 0;
      found = 1'b0;
      stop  = 1'b0;
      if (it.operation == OP_LOAD) begin
         // a 6-bit index always lands inside the table
         hole_free_model[it.hole_index] = it.hole_size;
         r.granted      = 1'b1;
         r.chosen_hole  = it.hole_index;
         r.left_in_hole = it.hole_size;
      end else begin
         // a count above the table size means the whole table
         used = (holes_in_use > HOLE_TOTAL) ? HOLE_TOTAL : int'(holes_in_use);
         for (int j = 0; j < used && !stop; j++) begin
            f = hole_free_model[j[HOLE_IDX_BITS-1:0]];
            if (it.request_size <= f) begin
               if (fit_sel == POLICY_BEST) begin
                  // smallest hole, later index wins a tie
                  if (!found || f <= hole_free_model[pick[HOLE_IDX_BITS-1:0]]) begin
                     pick  = j;
                     found = 1'b1;
                  end
               end else if (fit_sel == POLICY_WORST) begin
                  // largest hole, later index wins a tie
                  if (!found || f >= hole_free_model[pick[HOLE_IDX_BITS-1:0]]) begin
                     pick  = j;
                     found = 1'b1;
                  end
               end else begin
                  // first fit, also for the unused policy code
                  pick  = j;
                  found = 1'b1;
                  stop  = 1'b1;
               end
            end
         end
         if (found) begin
            hole_free_model[pick[HOLE_IDX_BITS-1:0]] =
               hole_free_model[pick[HOLE_IDX_BITS-1:0]] - it.request_size;
            r.granted      = 1'b1;
            r.chosen_hole  = pick[HOLE_IDX_BITS-1:0];
            r.left_in_hole = hole_free_model[pick[HOLE_IDX_BITS-1:0]];
         end
      end
      return r;
   endfunction

   // csr write, only issued while nothing is in flight
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FIT_POLICY) begin
         fit_sel = value[POLICY_BITS-1:0];
      end else begin
         holes_in_use = value;
      end
      csr_writes++;
   endtask

   task automatic queue_item(input hfa_op_type op, input logic [5:0] idx,
                             input logic [31:0] hsz, input logic [31:0] req);
      hfa_req_type it;
      it.operation    = op;
      it.hole_index   = idx;
      it.hole_size    = hsz;
      it.request_size = req;
      txn_q.push_back(it);
      outstanding++;
   endtask

   // loads carry a random request size, allocations a random index and size
   task automatic queue_load(input logic [5:0] idx, input logic [31:0] hsz);
      queue_item(OP_LOAD, idx, hsz, $urandom());
   endtask

   task automatic queue_alloc(input logic [31:0] req);
      queue_item(OP_ALLOC, 6'($urandom_range(0, HOLE_TOTAL - 1)), $urandom(), req);
   endtask

   // random transaction, sizes mostly small so that fits and ties are common
   task automatic queue_random_item();
      logic [31:0] hsz;
      logic [31:0] req;
      case ($urandom_range(0, 9))
         7, 8:    hsz = $urandom();
         9:       hsz = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: hsz = $urandom_range(0, 16) * 16;
      endcase
      case ($urandom_range(0, 9))
         6:       req = 32'h0;
         7, 8:    req = $urandom();
         9:       req = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(1, 255);
         default: req = $urandom_range(0, 10) * 16;
      endcase
      if ($urandom_range(0, 99) < 35) begin
         queue_item(OP_LOAD, 6'($urandom_range(0, HOLE_TOTAL - 1)), hsz, req);
      end else begin
         queue_item(OP_ALLOC, 6'($urandom_range(0, HOLE_TOTAL - 1)), hsz, req);
      end
   endtask

   // hold off until every queued transaction has been answered
   task automatic wait_drained();
      @(negedge clock);
      while (outstanding > 0) @(negedge clock);
   endtask

   // request driver: holds a transaction until it is taken, idles at random between
   always @(negedge clock) begin : drive_req
      hfa_req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (txn_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = txn_q.pop_front();
            req_if.valid        <= 1'b1;
            req_if.operation    <= nxt.operation;
            req_if.hole_index   <= nxt.hole_index;
            req_if.hole_size    <= nxt.hole_size;
            req_if.request_size <= nxt.request_size;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: predicts on accepted requests, checks accepted responses, watchdog
   always @(posedge clock) begin : watch_channels
      hfa_req_type    it;
      hfa_result_type want;
      req_taken <= req_if.valid && req_if.ready && !reset;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            it.operation    = req_if.operation;
            it.hole_index   = req_if.hole_index;
            it.hole_size    = req_if.hole_size;
            it.request_size = req_if.request_size;
            want = predict_grant(it);
            grant_q.push_back(want);
            if (it.operation == OP_LOAD) begin
               load_count++;
            end else begin
               alloc_count++;
               if (want.granted) grant_count++;
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            outstanding--;
            if (grant_q.size() == 0) begin
               report_mismatch("response with nothing expected, left_in_hole",
                               rsp_if.left_in_hole, 32'h0);
            end else begin
               want = grant_q.pop_front();
               if (rsp_if.granted !== want.granted)
                  report_mismatch("granted", 32'(rsp_if.granted), 32'(want.granted));
               if (rsp_if.chosen_hole !== want.chosen_hole)
                  report_mismatch("chosen_hole", 32'(rsp_if.chosen_hole),
                                  32'(want.chosen_hole));
               if (rsp_if.left_in_hole !== want.left_in_hole)
                  report_mismatch("left_in_hole", rsp_if.left_in_hole, want.left_in_hole);
            end
         end
         // no transaction on either side for too long means a hang
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   // stimulus: directed checks first, then random phases over several settings
   initial begin : stimulus
      logic [4:0] junk;
      clock               = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_FIT_POLICY;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.operation    = OP_LOAD;
      req_if.hole_index   = '0;
      req_if.hole_size    = '0;
      req_if.request_size = '0;
      rsp_if.ready        = 1'b0;
      req_taken           = 1'b0;
      fit_sel             = POLICY_FIRST;  // csr reset values
      holes_in_use        = '0;
      outstanding         = 0;
      error_count         = 0;
      quiet_cycles        = 0;
      load_count          = 0;
      alloc_count         = 0;
      grant_count         = 0;
      csr_writes          = 0;
      send_idle_pct       = 7;
      recv_idle_pct       = 68;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no hole in use after reset: nothing is granted, loads still answer
      queue_alloc(32'h0);
      queue_alloc(32'hFFFF_FFFF);
      queue_load(6'd0, 32'h0);
      queue_load(6'd1, 32'd100);
      queue_load(6'd2, 32'd100);
      queue_load(6'd3, 32'd50);
      queue_load(6'd63, 32'hFFFF_FFFF);
      queue_alloc(32'd5);
      // fill the rest of the table so any hole count is safe later
      for (int i = 4; i < HOLE_TOTAL - 1; i++) queue_load(i[5:0], $urandom_range(1, 40) * 8);
      wait_drained();

      // first fit over four holes, zero request takes the empty hole
      write_csr(CSR_FIT_POLICY, {5'd0, POLICY_FIRST});
      write_csr(CSR_HOLE_COUNT, 7'd4);
      queue_alloc(32'd0);
      queue_alloc(32'd60);
      queue_alloc(32'd100);
      queue_alloc(32'd200);
      wait_drained();

      // best fit: exact fit, then a tie between equal holes
      write_csr(CSR_FIT_POLICY, {5'd0, POLICY_BEST});
      queue_load(6'd0, 32'd10);
      queue_load(6'd1, 32'd80);
      queue_load(6'd2, 32'd80);
      queue_load(6'd3, 32'd50);
      queue_alloc(32'd50);
      queue_alloc(32'd60);
      wait_drained();

      // worst fit: largest hole, then a tie
      write_csr(CSR_FIT_POLICY, {5'd0, POLICY_WORST});
      queue_alloc(32'd10);
      queue_load(6'd0, 32'd70);
      queue_alloc(32'd5);
      wait_drained();

      // unused policy code acts as first fit, oversized count covers the whole table
      write_csr(CSR_FIT_POLICY, {5'd0, 2'd3});
      write_csr(CSR_HOLE_COUNT, 7'd127);
      queue_alloc(32'hFFFF_FFFF);
      queue_alloc(32'h0);
      wait_drained();

      // random phases
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES / 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 7;
         end else if (ph == 2 * PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // upper data bits are dropped by the policy register
         junk = 5'($urandom_range(0, 31));
         write_csr(CSR_FIT_POLICY, {junk, policy_plan[ph[3:0]]});
         write_csr(CSR_HOLE_COUNT, count_plan[ph[3:0]]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // in phase 5 the sender holds off mid-phase until every response is back
            if (ph == 5 && n == PHASE_ITEMS / 2) wait_drained();
            queue_random_item();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grant_q.size() != 0)
         report_mismatch("responses never seen, count", 32'd0, 32'(grant_q.size()));

      $display("covered %0d loads and %0d allocations (%0d granted)", load_count,
               alloc_count, grant_count);
      $display("over %0d csr writes across first, best, worst and unused policy codes",
               csr_writes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
